// ===== sv/lvm_pkg.sv =====
// Package for the look-at view matrix block: widths, request and response types,
// the queue entry type and shared constants. No dependencies.
package lvm_pkg;

   localparam int FRAC_BITS = 16;
   localparam int WORD_BITS = 32;
   localparam int NORM_BITS = 30;

   localparam int DIR_W  = WORD_BITS + 1;
   localparam int AX_W   = FRAC_BITS + 4;
   localparam int VEC_W  = NORM_BITS + AX_W + 2;
   localparam int MA_W   = ((WORD_BITS > NORM_BITS + 2) ? WORD_BITS : NORM_BITS + 2) + 1;
   localparam int MB_W   = NORM_BITS + 2;
   localparam int PROD_W = MA_W + MB_W;
   localparam int ACC_W  = PROD_W + 2;
   localparam int SQ_W   = 2 * NORM_BITS + 2;
   localparam int RT_W   = SQ_W / 2;
   localparam int ISQ_STEPS = SQ_W / 2;
   localparam int ISQ_CNT_W = $clog2(ISQ_STEPS);
   localparam int NUM_W  = NORM_BITS + FRAC_BITS + 2;
   localparam int Q_W    = FRAC_BITS + 1;
   localparam int Q_CNT_W = $clog2(Q_W);

   localparam logic [SQ_W-1:0] SQ_ONE = 1;
   localparam logic [SQ_W-1:0] SQ_TOP_BIT = SQ_ONE << (SQ_W - 2);

   typedef struct packed {
      logic signed [WORD_BITS-1:0] eye_x;
      logic signed [WORD_BITS-1:0] eye_y;
      logic signed [WORD_BITS-1:0] eye_z;
      logic signed [WORD_BITS-1:0] target_x;
      logic signed [WORD_BITS-1:0] target_y;
      logic signed [WORD_BITS-1:0] target_z;
      logic signed [WORD_BITS-1:0] up_x;
      logic signed [WORD_BITS-1:0] up_y;
      logic signed [WORD_BITS-1:0] up_z;
   } req_type;

   typedef struct packed {
      logic [1:0]                  row_index;
      logic signed [WORD_BITS-1:0] elem_a;
      logic signed [WORD_BITS-1:0] elem_b;
      logic signed [WORD_BITS-1:0] elem_c;
      logic                        degenerate;
      logic                        last_row;
   } rsp_type;

   typedef struct packed {
      logic [2:0][WORD_BITS-1:0] eye;
      logic [2:0][DIR_W-1:0]     dir;
      logic [2:0][WORD_BITS-1:0] up;
   } job_type;

endpackage

// ===== sv/lvm_front.sv =====
// Front end: takes a request, forms target minus eye and holds the job
// until the queue takes it. Depends on lvm_pkg.
module lvm_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lvm_pkg::req_type req_data,
   output logic             push_valid,
   output lvm_pkg::job_type push_job,
   input  logic             push_ready
);
   import lvm_pkg::*;

   logic    hold_ff, hold_in;
   job_type job_ff, job_in;
   logic    load;

   assign load      = !hold_ff || push_ready;
   assign req_stall = !load;
   assign push_valid = hold_ff;
   assign push_job   = job_ff;

   always_comb begin
      hold_in = hold_ff && !push_ready;
      job_in  = job_ff;
      if (load && req_valid) begin
         hold_in = 1'b1;
         job_in.eye[0] = req_data.eye_x;
         job_in.eye[1] = req_data.eye_y;
         job_in.eye[2] = req_data.eye_z;
         job_in.up[0]  = req_data.up_x;
         job_in.up[1]  = req_data.up_y;
         job_in.up[2]  = req_data.up_z;
         job_in.dir[0] = DIR_W'(req_data.target_x) - DIR_W'(req_data.eye_x);
         job_in.dir[1] = DIR_W'(req_data.target_y) - DIR_W'(req_data.eye_y);
         job_in.dir[2] = DIR_W'(req_data.target_z) - DIR_W'(req_data.eye_z);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 1'b0;
      end else begin
         hold_ff <= hold_in;
      end
      job_ff <= job_in;
   end

endmodule

// ===== sv/lvm_queue.sv =====
// Two-entry job queue between front and back end.
// Depends on lvm_pkg.
module lvm_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  lvm_pkg::job_type push_job,
   output logic             push_ready,
   output logic             pop_valid,
   output lvm_pkg::job_type pop_job,
   input  logic             pop
);
   import lvm_pkg::*;

   job_type [1:0] mem_ff;
   logic          wr_ff, rd_ff;
   logic [1:0]    count_ff, count_in;
   logic          do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_job    = mem_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (do_push) wr_ff <= !wr_ff;
         if (do_pop)  rd_ff <= !rd_ff;
      end
      if (do_push) mem_ff[wr_ff] <= push_job;
   end

endmodule

// ===== sv/lvm_isqrt.sv =====
// Iterative floor integer square root, one result bit per cycle.
// Depends on lvm_pkg.
module lvm_isqrt (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [lvm_pkg::SQ_W-1:0] n_val,
   output logic                     done,
   output logic [lvm_pkg::RT_W-1:0] root
);
   import lvm_pkg::*;

   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [SQ_W-1:0]      n_ff, n_in, r_ff, r_in, bit_ff, bit_in, trial;
   logic [ISQ_CNT_W-1:0] cnt_ff, cnt_in;

   assign trial = r_ff + bit_ff;
   assign done  = done_ff;
   assign root  = r_ff[RT_W-1:0];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      n_in    = n_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         n_in    = n_val;
         r_in    = '0;
         bit_in  = SQ_TOP_BIT;
         cnt_in  = ISQ_CNT_W'(ISQ_STEPS - 1);
      end else if (busy_ff) begin
         if (n_ff >= trial) begin
            n_in = n_ff - trial;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      n_ff   <= n_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
      cnt_ff <= cnt_in;
   end

endmodule

// ===== sv/lvm_div.sv =====
// Restoring divider, one quotient bit per cycle, for the unit-vector components.
// Depends on lvm_pkg.
module lvm_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [lvm_pkg::NUM_W-1:0] num,
   input  logic [lvm_pkg::RT_W-1:0]  den,
   output logic                      done,
   output logic [lvm_pkg::Q_W-1:0]   quo
);
   import lvm_pkg::*;

   logic               busy_ff, busy_in, done_ff, done_in;
   logic [NUM_W-1:0]   rem_ff, rem_in, dsh_ff, dsh_in;
   logic [Q_W-1:0]     q_ff, q_in;
   logic [Q_CNT_W-1:0] cnt_ff, cnt_in;

   assign done = done_ff;
   assign quo  = q_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         rem_in  = num;
         dsh_in  = NUM_W'(den) << (Q_W - 1);
         q_in    = '0;
         cnt_in  = Q_CNT_W'(Q_W - 1);
      end else if (busy_ff) begin
         if (rem_ff >= dsh_ff) begin
            rem_in = rem_ff - dsh_ff;
            q_in   = {q_ff[Q_W-2:0], 1'b1};
         end else begin
            q_in   = {q_ff[Q_W-2:0], 1'b0};
         end
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

endmodule

// ===== sv/lvm_back.sv =====
// Back end: sequencer with a shared multiply-accumulate, prescaler, square root
// and divider, and the response register. Depends on lvm_pkg, lvm_isqrt, lvm_div.
module lvm_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  lvm_pkg::job_type job,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lvm_pkg::rsp_type rsp_data
);
   import lvm_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_PRE   = 9'b000000010,
      S_SQ    = 9'b000000100,
      S_SQRT  = 9'b000001000,
      S_DIV   = 9'b000010000,
      S_CROSS = 9'b000100000,
      S_UAX   = 9'b001000000,
      S_TRANS = 9'b010000000,
      S_EMIT  = 9'b100000000
   } state_type;

   localparam logic [1:0] PASS_DIR   = 2'd0;
   localparam logic [1:0] PASS_UP    = 2'd1;
   localparam logic [1:0] PASS_CROSS = 2'd2;
   localparam logic [1:0] ROW_TRANS  = 2'd3;

   localparam logic [VEC_W-1:0] V_ONE    = 1;
   localparam logic [VEC_W-1:0] LIM_R8   = V_ONE << (NORM_BITS + 8);
   localparam logic [VEC_W-1:0] LIM_R1   = V_ONE << NORM_BITS;
   localparam logic [VEC_W-1:0] LIM_L8   = V_ONE << (NORM_BITS - 9);
   localparam logic [VEC_W-1:0] LIM_L1   = V_ONE << (NORM_BITS - 1);
   localparam logic [ACC_W-1:0] A_ONE    = 1;
   localparam logic signed [ACC_W-1:0] HALF  = A_ONE << (FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] W_MAX = (A_ONE << (WORD_BITS - 1)) - A_ONE;
   localparam logic signed [ACC_W-1:0] W_MIN = -W_MAX - A_ONE;

   function automatic logic [VEC_W-1:0] mag(input logic [VEC_W-1:0] v);
      mag = v[VEC_W-1] ? -v : v;
   endfunction

   function automatic logic [1:0] xa(input logic [3:0] k);
      case (k)
         4'd0:    xa = 2'd1;
         4'd1:    xa = 2'd2;
         4'd2:    xa = 2'd2;
         4'd3:    xa = 2'd0;
         4'd4:    xa = 2'd0;
         4'd5:    xa = 2'd1;
         default: xa = 2'd0;
      endcase
   endfunction

   function automatic logic [1:0] xb(input logic [3:0] k);
      case (k)
         4'd0:    xb = 2'd2;
         4'd1:    xb = 2'd1;
         4'd2:    xb = 2'd0;
         4'd3:    xb = 2'd2;
         4'd4:    xb = 2'd1;
         4'd5:    xb = 2'd0;
         default: xb = 2'd0;
      endcase
   endfunction

   function automatic logic [1:0] tcomp(input logic [3:0] k);
      case (k)
         4'd0, 4'd1, 4'd2: tcomp = 2'd0;
         4'd3, 4'd4, 4'd5: tcomp = 2'd1;
         default:          tcomp = 2'd2;
      endcase
   endfunction

   function automatic logic [1:0] tidx(input logic [3:0] k);
      case (k)
         4'd0, 4'd3, 4'd6: tidx = 2'd0;
         4'd1, 4'd4, 4'd7: tidx = 2'd1;
         default:          tidx = 2'd2;
      endcase
   endfunction

   function automatic logic [WORD_BITS-1:0] sat_word(input logic signed [ACC_W-1:0] v);
      if (v > W_MAX) begin
         sat_word = W_MAX[WORD_BITS-1:0];
      end else if (v < W_MIN) begin
         sat_word = W_MIN[WORD_BITS-1:0];
      end else begin
         sat_word = v[WORD_BITS-1:0];
      end
   endfunction

   function automatic logic [WORD_BITS-1:0] ax_word(input logic [AX_W-1:0] v);
      ax_word = {{(WORD_BITS-AX_W){v[AX_W-1]}}, v};
   endfunction

   function automatic logic [MB_W-1:0] ax_mb(input logic [AX_W-1:0] v);
      ax_mb = {{(MB_W-AX_W){v[AX_W-1]}}, v};
   endfunction

   state_type state_ff, state_in;
   logic [3:0] k_ff, k_in;
   logic [1:0] pass_ff, pass_in, row_ff, row_in;
   logic       wait_ff, wait_in, degen_ff, degen_in;
   logic [2:0][WORD_BITS-1:0] eye_ff, eye_in, up_ff, up_in, t_ff, t_in;
   logic [2:0][VEC_W-1:0]     vec_ff, vec_in;
   logic [2:0][MA_W-1:0]      ups_ff, ups_in;
   logic [2:0][AX_W-1:0]      f_ff, f_in, s_ff, s_in, u_ff, u_in;
   logic [VEC_W-1:0]          m_ff, m_in, m0, m1, m2, m01, mk;
   logic [SQ_W-1:0]           sq_ff, sq_in;
   logic [RT_W-1:0]           len_ff, len_in;

   logic              tag_v_ff, tag_first_ff, tag_sub_ff, tag_last_ff;
   logic              issue, t_first, t_sub, t_last;
   logic [1:0]        tag_dst_ff, t_dst;
   logic [MA_W-1:0]   mul_a;
   logic [MB_W-1:0]   mul_b;
   logic signed [PROD_W-1:0] prod_in, prod_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in, acc_next, prod_x, rnd;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;
   logic            out_free;

   logic            sq_start, sq_done, dv_start, dv_done;
   logic [RT_W-1:0] root;
   logic [Q_W-1:0]  quo;
   logic [NUM_W-1:0] dv_num;
   logic [AX_W-1:0]  q_ax;

   lvm_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .n_val (sq_ff),
      .done  (sq_done),
      .root  (root)
   );

   lvm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (dv_start),
      .num   (dv_num),
      .den   (len_ff),
      .done  (dv_done),
      .quo   (quo)
   );

   assign m0  = mag(vec_ff[0]);
   assign m1  = mag(vec_ff[1]);
   assign m2  = mag(vec_ff[2]);
   assign m01 = (m0 > m1) ? m0 : m1;
   assign mk  = mag(vec_ff[k_ff[1:0]]);
   assign dv_num = (NUM_W'(mk[NORM_BITS:0]) << FRAC_BITS) + NUM_W'(len_ff >> 1);
   assign q_ax = vec_ff[k_ff[1:0]][VEC_W-1] ? -AX_W'(quo) : AX_W'(quo);

   assign prod_in  = $signed(mul_a) * $signed(mul_b);
   assign prod_x   = {{2{prod_ff[PROD_W-1]}}, prod_ff};
   assign acc_next = (tag_first_ff ? '0 : acc_ff) + (tag_sub_ff ? -prod_x : prod_x);
   assign rnd      = (acc_next + HALF) >>> FRAC_BITS;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      pass_in  = pass_ff;
      row_in   = row_ff;
      wait_in  = wait_ff;
      degen_in = degen_ff;
      eye_in   = eye_ff;
      up_in    = up_ff;
      t_in     = t_ff;
      vec_in   = vec_ff;
      ups_in   = ups_ff;
      f_in     = f_ff;
      s_in     = s_ff;
      u_in     = u_ff;
      m_in     = m_ff;
      sq_in    = sq_ff;
      len_in   = len_ff;
      pop      = 1'b0;
      sq_start = 1'b0;
      dv_start = 1'b0;
      issue    = 1'b0;
      t_first  = 1'b0;
      t_sub    = 1'b0;
      t_last   = 1'b0;
      t_dst    = 2'd0;
      mul_a    = '0;
      mul_b    = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               pop      = 1'b1;
               eye_in   = job.eye;
               up_in    = job.up;
               for (int i = 0; i < 3; i++) begin
                  vec_in[i] = {{(VEC_W-DIR_W){job.dir[i][DIR_W-1]}}, job.dir[i]};
               end
               pass_in  = PASS_DIR;
               degen_in = 1'b0;
               k_in     = 4'd0;
               state_in = S_PRE;
            end
         end
         S_PRE: begin
            if (k_ff == 4'd0) begin
               m_in = (m01 > m2) ? m01 : m2;
               k_in = 4'd1;
            end else if (m_ff == '0) begin
               k_in = 4'd0;
               case (pass_ff)
                  PASS_DIR: begin
                     f_in     = '0;
                     degen_in = 1'b1;
                     for (int i = 0; i < 3; i++) begin
                        vec_in[i] = {{(VEC_W-WORD_BITS){up_ff[i][WORD_BITS-1]}}, up_ff[i]};
                     end
                     pass_in  = PASS_UP;
                  end
                  PASS_UP: begin
                     ups_in   = '0;
                     state_in = S_CROSS;
                  end
                  default: begin
                     s_in     = '0;
                     degen_in = 1'b1;
                     state_in = S_UAX;
                  end
               endcase
            end else if (m_ff >= LIM_R8) begin
               m_in = m_ff >> 8;
               for (int i = 0; i < 3; i++) vec_in[i] = VEC_W'($signed(vec_ff[i]) >>> 8);
            end else if (m_ff >= LIM_R1) begin
               m_in = m_ff >> 1;
               for (int i = 0; i < 3; i++) vec_in[i] = VEC_W'($signed(vec_ff[i]) >>> 1);
            end else if (m_ff < LIM_L8) begin
               m_in = m_ff << 8;
               for (int i = 0; i < 3; i++) vec_in[i] = vec_ff[i] << 8;
            end else if (m_ff < LIM_L1) begin
               m_in = m_ff << 1;
               for (int i = 0; i < 3; i++) vec_in[i] = vec_ff[i] << 1;
            end else begin
               k_in = 4'd0;
               if (pass_ff == PASS_UP) begin
                  for (int i = 0; i < 3; i++) ups_in[i] = vec_ff[i][MA_W-1:0];
                  state_in = S_CROSS;
               end else begin
                  state_in = S_SQ;
               end
            end
         end
         S_SQ: begin
            if (k_ff < 4'd3) begin
               issue   = 1'b1;
               mul_a   = vec_ff[k_ff[1:0]][MA_W-1:0];
               mul_b   = vec_ff[k_ff[1:0]][MB_W-1:0];
               t_first = (k_ff == 4'd0);
               t_last  = (k_ff == 4'd2);
               k_in    = k_ff + 4'd1;
            end else begin
               wait_in  = 1'b0;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            if (!wait_ff) begin
               sq_start = 1'b1;
               wait_in  = 1'b1;
            end else if (sq_done) begin
               len_in   = root;
               wait_in  = 1'b0;
               k_in     = 4'd0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (!wait_ff) begin
               dv_start = 1'b1;
               wait_in  = 1'b1;
            end else if (dv_done) begin
               wait_in = 1'b0;
               if (pass_ff == PASS_DIR) begin
                  f_in[k_ff[1:0]] = q_ax;
               end else begin
                  s_in[k_ff[1:0]] = q_ax;
               end
               if (k_ff == 4'd2) begin
                  k_in = 4'd0;
                  if (pass_ff == PASS_DIR) begin
                     for (int i = 0; i < 3; i++) begin
                        vec_in[i] = {{(VEC_W-WORD_BITS){up_ff[i][WORD_BITS-1]}}, up_ff[i]};
                     end
                     pass_in  = PASS_UP;
                     state_in = S_PRE;
                  end else begin
                     state_in = S_UAX;
                  end
               end else begin
                  k_in = k_ff + 4'd1;
               end
            end
         end
         S_CROSS: begin
            if (k_ff < 4'd6) begin
               issue   = 1'b1;
               mul_a   = ups_ff[xa(k_ff)];
               mul_b   = ax_mb(f_ff[xb(k_ff)]);
               t_first = !k_ff[0];
               t_sub   = k_ff[0];
               t_last  = k_ff[0];
               t_dst   = k_ff[2:1];
               k_in    = k_ff + 4'd1;
            end else begin
               k_in     = 4'd0;
               pass_in  = PASS_CROSS;
               state_in = S_PRE;
            end
         end
         S_UAX: begin
            if (k_ff < 4'd6) begin
               issue   = 1'b1;
               mul_a   = {{(MA_W-AX_W){f_ff[xa(k_ff)][AX_W-1]}}, f_ff[xa(k_ff)]};
               mul_b   = ax_mb(s_ff[xb(k_ff)]);
               t_first = !k_ff[0];
               t_sub   = k_ff[0];
               t_last  = k_ff[0];
               t_dst   = k_ff[2:1];
               k_in    = k_ff + 4'd1;
            end else begin
               k_in     = 4'd0;
               state_in = S_TRANS;
            end
         end
         S_TRANS: begin
            if (k_ff < 4'd9) begin
               issue   = 1'b1;
               mul_a   = {{(MA_W-WORD_BITS){eye_ff[tidx(k_ff)][WORD_BITS-1]}},
                          eye_ff[tidx(k_ff)]};
               case (tcomp(k_ff))
                  2'd0:    mul_b = ax_mb(s_ff[tidx(k_ff)]);
                  2'd1:    mul_b = ax_mb(u_ff[tidx(k_ff)]);
                  default: mul_b = ax_mb(f_ff[tidx(k_ff)]);
               endcase
               t_first = (tidx(k_ff) == 2'd0);
               t_last  = (tidx(k_ff) == 2'd2);
               t_dst   = tcomp(k_ff);
               k_in    = k_ff + 4'd1;
            end else begin
               row_in   = 2'd0;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.row_index  = row_ff;
               rsp_data_in.degenerate = degen_ff;
               rsp_data_in.last_row   = (row_ff == ROW_TRANS);
               if (row_ff == ROW_TRANS) begin
                  rsp_data_in.elem_a = t_ff[0];
                  rsp_data_in.elem_b = t_ff[1];
                  rsp_data_in.elem_c = t_ff[2];
                  state_in = S_IDLE;
               end else begin
                  rsp_data_in.elem_a = ax_word(s_ff[row_ff]);
                  rsp_data_in.elem_b = ax_word(u_ff[row_ff]);
                  rsp_data_in.elem_c = ax_word(f_ff[row_ff]);
               end
               row_in = row_ff + 2'd1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (tag_v_ff && tag_last_ff) begin
         case (state_ff)
            S_SQ:    sq_in = acc_next[SQ_W-1:0];
            S_CROSS: vec_in[tag_dst_ff] = acc_next[VEC_W-1:0];
            S_UAX:   u_in[tag_dst_ff] = rnd[AX_W-1:0];
            S_TRANS: t_in[tag_dst_ff] = sat_word(-rnd);
            default: ;
         endcase
      end
      acc_in = tag_v_ff ? acc_next : acc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         k_ff         <= 4'd0;
         wait_ff      <= 1'b0;
         tag_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         wait_ff      <= wait_in;
         tag_v_ff     <= issue;
         rsp_valid_ff <= rsp_valid_in;
      end
      pass_ff      <= pass_in;
      row_ff       <= row_in;
      degen_ff     <= degen_in;
      eye_ff       <= eye_in;
      up_ff        <= up_in;
      t_ff         <= t_in;
      vec_ff       <= vec_in;
      ups_ff       <= ups_in;
      f_ff         <= f_in;
      s_ff         <= s_in;
      u_ff         <= u_in;
      m_ff         <= m_in;
      sq_ff        <= sq_in;
      len_ff       <= len_in;
      tag_first_ff <= t_first;
      tag_sub_ff   <= t_sub;
      tag_last_ff  <= t_last;
      tag_dst_ff   <= t_dst;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule

// ===== sv/lookat_view_matrix.sv =====
// Top level of the left-handed look-at view matrix block: front end, job queue
// and back end. Depends on lvm_pkg, lvm_front, lvm_queue, lvm_back.
//
//   channel  ports                          moves
//   input    req_valid req_stall req_data   one request: eye, target, up
//   output   rsp_valid rsp_stall rsp_data   four rows per request, row 3 last
//
// A request's back-end time is set by the bit-serial square root (31 steps) and
// divider (17 steps per component), each run twice unless an axis is zero, plus
// prescaling and the shared multiply-accumulate sequences.
// The front end and two-entry queue take new requests while the back end works.
// Reset is synchronous and clears all control state; no clearing pass.
// rsp_stall holds the response register; the back end waits only to load it.
module lookat_view_matrix (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lvm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lvm_pkg::rsp_type rsp_data
);
   import lvm_pkg::*;

   logic    push_valid, push_ready, pop_valid, pop;
   job_type push_job, pop_job;

   lvm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready)
   );

   lvm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job),
      .pop        (pop)
   );

   lvm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (pop_valid),
      .job       (pop_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== tb/lookat_view_matrix_chk.sv =====
`timescale 1ns / 1ps
// Checker for the look-at view matrix block: watches both channels, predicts the
// four rows of each accepted request and compares them. Depends on lvm_pkg.
module lookat_view_matrix_chk (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  lvm_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  lvm_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending_rows,
   output int               rows_seen,
   output int               degen_seen
);
   import lvm_pkg::*;

   localparam longint SAT_HI = 64'sd2147483647;
   localparam longint SAT_LO = -64'sd2147483648;

   rsp_type row_queue[$];

   function automatic longint sat32(longint v);
      if (v > SAT_HI) return SAT_HI;
      if (v < SAT_LO) return SAT_LO;
      return v;
   endfunction

   function automatic longint rnd_shift(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint mag(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic longint root64(longint n);
      longint unsigned x, r, b;
      x = n;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic bit scale_vec(input longint v[3], output longint o[3]);
      longint m;
      int n;
      m = 0;
      for (int i = 0; i < 3; i++) if (mag(v[i]) > m) m = mag(v[i]);
      for (int i = 0; i < 3; i++) o[i] = 0;
      if (m == 0) return 0;
      n = 0;
      while ((m >> n) != 0) n++;
      for (int i = 0; i < 3; i++)
         o[i] = (n > NORM_BITS) ? (v[i] >>> (n - NORM_BITS)) : (v[i] <<< (NORM_BITS - n));
      return 1;
   endfunction

   function automatic bit unit_vec(input longint v[3], output longint u[3]);
      longint p[3];
      longint unsigned sq, len, a, q;
      for (int i = 0; i < 3; i++) u[i] = 0;
      if (!scale_vec(v, p)) return 0;
      sq = 0;
      for (int i = 0; i < 3; i++) sq += mag(p[i]) * mag(p[i]);
      len = root64(sq);
      for (int i = 0; i < 3; i++) begin
         a = mag(p[i]);
         q = ((a << FRAC_BITS) + (len >> 1)) / len;
         u[i] = (p[i] < 0) ? -longint'(q) : longint'(q);
      end
      return 1;
   endfunction

   function automatic longint translation(longint ax[3], longint e[3]);
      longint hi, lo, eh;
      hi = 0;
      lo = 0;
      for (int i = 0; i < 3; i++) begin
         eh = e[i] >>> FRAC_BITS;
         hi += eh * ax[i];
         lo += (e[i] - (eh <<< FRAC_BITS)) * ax[i];
      end
      return sat32(-(hi + rnd_shift(lo, FRAC_BITS)));
   endfunction

   task automatic predict_matrix(req_type r);
      longint e[3], d[3], up[3], ups[3], cr[3], f[3], s[3], u[3];
      bit degen;
      rsp_type row;
      e  = '{longint'(r.eye_x), longint'(r.eye_y), longint'(r.eye_z)};
      d  = '{longint'(r.target_x) - e[0], longint'(r.target_y) - e[1],
             longint'(r.target_z) - e[2]};
      up = '{longint'(r.up_x), longint'(r.up_y), longint'(r.up_z)};
      degen = 0;
      if (!unit_vec(d, f)) degen = 1;
      void'(scale_vec(up, ups));
      cr[0] = ups[1] * f[2] - ups[2] * f[1];
      cr[1] = ups[2] * f[0] - ups[0] * f[2];
      cr[2] = ups[0] * f[1] - ups[1] * f[0];
      if (!unit_vec(cr, s)) degen = 1;
      u[0] = rnd_shift(f[1] * s[2] - f[2] * s[1], FRAC_BITS);
      u[1] = rnd_shift(f[2] * s[0] - f[0] * s[2], FRAC_BITS);
      u[2] = rnd_shift(f[0] * s[1] - f[1] * s[0], FRAC_BITS);
      for (int i = 0; i < 4; i++) begin
         row.row_index = i[1:0];
         if (i < 3) begin
            row.elem_a = 32'(sat32(s[i]));
            row.elem_b = 32'(sat32(u[i]));
            row.elem_c = 32'(sat32(f[i]));
         end else begin
            row.elem_a = 32'(translation(s, e));
            row.elem_b = 32'(translation(u, e));
            row.elem_c = 32'(translation(f, e));
         end
         row.degenerate = degen;
         row.last_row = (i == 3);
         row_queue.push_back(row);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fail_count <= 0;
         rows_seen <= 0;
         degen_seen <= 0;
         pending_rows <= 0;
      end else begin
         if (req_valid && !req_stall) predict_matrix(req_data);
         if (rsp_valid && !rsp_stall) begin
            rows_seen <= rows_seen + 1;
            if (rsp_data.degenerate) degen_seen <= degen_seen + 1;
            if (row_queue.size() == 0) begin
               $error("row with no request outstanding");
               fail_count <= fail_count + 1;
            end else begin
               rsp_type x;
               int bad;
               x = row_queue.pop_front();
               bad = 0;
               if (rsp_data.row_index !== x.row_index) begin
                  $error("row_index exp %0d got %0d", x.row_index, rsp_data.row_index);
                  bad++;
               end
               if (rsp_data.elem_a !== x.elem_a) begin
                  $error("elem_a exp %0d got %0d", x.elem_a, rsp_data.elem_a);
                  bad++;
               end
               if (rsp_data.elem_b !== x.elem_b) begin
                  $error("elem_b exp %0d got %0d", x.elem_b, rsp_data.elem_b);
                  bad++;
               end
               if (rsp_data.elem_c !== x.elem_c) begin
                  $error("elem_c exp %0d got %0d", x.elem_c, rsp_data.elem_c);
                  bad++;
               end
               if (rsp_data.degenerate !== x.degenerate) begin
                  $error("degenerate exp %0b got %0b", x.degenerate, rsp_data.degenerate);
                  bad++;
               end
               if (rsp_data.last_row !== x.last_row) begin
                  $error("last_row exp %0b got %0b", x.last_row, rsp_data.last_row);
                  bad++;
               end
               fail_count <= fail_count + bad;
            end
         end
         pending_rows <= row_queue.size();
      end
   end

endmodule

// ===== tb/lookat_view_matrix_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the look-at view matrix block: clock, reset, request stimulus,
// response stalling and verdict. Depends on lvm_pkg, lookat_view_matrix and lookat_view_matrix_chk.
module lookat_view_matrix_tb;
   import lvm_pkg::*;

   localparam int N_RANDOM = 340;
   localparam longint CYCLE_LIMIT = 2000000;
   localparam logic [31:0] MAXP = 32'h7fffffff;
   localparam logic [31:0] MAXN = 32'h80000000;
   localparam logic [31:0] ONE  = 32'h00010000;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   rsp_type rsp_data;
   int      fail_count, pending_rows, rows_seen, degen_seen;
   bit      idle_on = 1;
   bit      hold_off = 0;
   longint  cycles = 0;
   int      sent = 0;

   always #2 clock = ~clock;

   lookat_view_matrix dut (.*);

   lookat_view_matrix_chk chk (.*);

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
         2: return 32'($signed($urandom_range(0, 200)) - 100);
         3: return $urandom_range(0, 1) ? MAXP : MAXN;
         default: return 32'($signed($urandom_range(0, 2000 << 16)) - (1000 << 16));
      endcase
   endfunction

   function automatic req_type rand_request();
      req_type r;
      r.eye_x = rand_coord(); r.eye_y = rand_coord(); r.eye_z = rand_coord();
      r.target_x = rand_coord(); r.target_y = rand_coord(); r.target_z = rand_coord();
      r.up_x = rand_coord(); r.up_y = rand_coord(); r.up_z = rand_coord();
      case ($urandom_range(0, 19))
         0: {r.target_x, r.target_y, r.target_z} = {r.eye_x, r.eye_y, r.eye_z};
         1: {r.up_x, r.up_y, r.up_z} = '0;
         2: begin
            r.up_x = r.target_x - r.eye_x;
            r.up_y = r.target_y - r.eye_y;
            r.up_z = r.target_z - r.eye_z;
         end
         3: begin
            r.up_x = 0; r.up_y = ONE; r.up_z = 0;
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic send(req_type r);
      while (idle_on && $urandom_range(0, 99) < 35) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_off) rsp_stall <= 1;
      else if (idle_on) rsp_stall <= ($urandom_range(0, 99) < 35);
      else rsp_stall <= 0;
   end

   initial begin
      req_type d[$];
      req_type r;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      r = '0; r.target_z = ONE; r.up_y = ONE; d.push_back(r);
      r = '0; r.eye_x = 5 << 16; r.eye_y = 3 << 16; r.eye_z = -(7 << 16);
      r.target_x = 1; r.up_y = ONE; d.push_back(r);
      r = '0; r.eye_x = MAXP; r.eye_y = MAXP; r.eye_z = MAXP;
      r.target_x = MAXN; r.target_y = MAXN; r.target_z = MAXN; r.up_z = MAXP;
      d.push_back(r);
      r = '0; r.eye_x = MAXN; r.eye_y = MAXN; r.eye_z = MAXN;
      r.target_x = MAXP; r.target_y = 0; r.target_z = MAXP;
      r.up_x = MAXN; r.up_y = MAXN; r.up_z = MAXN; d.push_back(r);
      r = '0; r.eye_x = MAXP; r.eye_y = MAXN; r.eye_z = MAXP;
      r.target_x = MAXP; r.target_y = MAXN; r.target_z = MAXP; r.up_y = ONE;
      d.push_back(r);
      r = '0; r.eye_x = ONE; r.target_x = 3 << 16; r.up_y = 1; d.push_back(r);
      r = '0; r.target_y = ONE; r.up_y = 5 << 16; d.push_back(r);
      r = '0; r.target_y = ONE; r.up_y = -ONE; d.push_back(r);
      r = '0; r.target_x = 1; r.target_y = 1; r.target_z = -1;
      r.up_x = MAXP; r.up_y = 1; d.push_back(r);
      r = '1; r.target_x = 0; r.up_x = 32'hffff0000; d.push_back(r);
      r = '0; r.eye_x = 32'h55555555; r.eye_y = 32'haaaaaaaa; r.eye_z = 32'h12345678;
      r.target_x = 32'haaaaaaaa; r.target_y = 32'h55555555; r.target_z = 32'hedcba987;
      r.up_x = 32'h0f0f0f0f; r.up_y = 32'hf0f0f0f0; r.up_z = 32'h33333333;
      d.push_back(r);
      foreach (d[i]) send(d[i]);

      // let the output back up while requests keep coming
      hold_off = 1;
      fork
         begin
            repeat (3000) @(posedge clock);
            hold_off = 0;
         end
         repeat (6) send(rand_request());
      join

      // drain fully, then a stretch with no idling
      req_valid <= 0;
      repeat (2) @(posedge clock);
      wait (pending_rows == 0);
      idle_on = 0;
      repeat (40) send(rand_request());
      idle_on = 1;
      for (int i = 0; i < N_RANDOM - 40; i++) send(rand_request());
      req_valid <= 0;
      repeat (2) @(posedge clock);

      wait (pending_rows == 0);
      repeat (300) @(posedge clock);
      $display("%0d requests sent, %0d rows checked, %0d rows flagged degenerate",
               sent, rows_seen, degen_seen);
      if (fail_count == 0 && pending_rows == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
